// File: src/amp_pkg.sv
// shared constants, codes and control types for the accelerometer peak detector
`timescale 1ns / 1ps
package amp_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned MAG_W           = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOCK_THRESHOLD = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WIN_RESET = 16'd500;
  localparam logic [CFG_DATA_W-1:0] THR_RESET = 16'd31130;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_UPDATE
  } amp_state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       acc_en;
    logic [1:0] axis;
    logic       root_en;
    logic       upd;
  } amp_cmd_t;

  typedef struct packed {
    logic emit;
  } amp_status_t;

endpackage

// File: src/amp_sample_if.sv
// handshake channel carrying one three-axis accelerometer sample
`timescale 1ns / 1ps
interface amp_sample_if
  import amp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] accel_x;
  logic signed [FIELD_W-1:0] accel_y;
  logic signed [FIELD_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// File: src/amp_peak_if.sv
// handshake channel carrying one reported window peak
`timescale 1ns / 1ps
interface amp_peak_if
  import amp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] peak_magnitude;

  modport source (output valid, output peak_magnitude, input ready);
  modport sink   (input valid, input peak_magnitude, output ready);
endinterface

// File: src/amp_datapath.sv
// datapath: squaring, digit-by-digit square root, window peak and config registers
`timescale 1ns / 1ps
module amp_datapath
  import amp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [FIELD_W-1:0] accel_x_i,
  input  logic signed [FIELD_W-1:0] accel_y_i,
  input  logic signed [FIELD_W-1:0] accel_z_i,
  input  amp_cmd_t                  cmd_i,
  output amp_status_t               status_o,
  output logic [MAG_W-1:0]          peak_magnitude_o
);

  localparam int unsigned AW  = SAMPLE_BITS;
  localparam int unsigned CW  = (AW < FIELD_W) ? AW : FIELD_W;
  localparam int unsigned SW  = 2 * AW;
  localparam int unsigned RW  = AW + 2;
  localparam int unsigned MW  = (AW > MAG_W) ? AW : MAG_W;

  logic [CFG_DATA_W-1:0] win_len_q, win_len_d;
  logic [CFG_DATA_W-1:0] thr_q, thr_d;
  logic [MAG_W-1:0]      count_q, count_d;
  logic [MAG_W-1:0]      peak_q, peak_d;

  logic [AW-1:0] ax_q, ay_q, az_q;
  logic [SW-1:0] prod_q;
  logic [SW-1:0] acc_q;
  logic [RW-1:0] rem_q;
  logic [AW-1:0] root_q;
  logic [MAG_W-1:0] out_q;

  logic [AW-1:0] ext_x, ext_y, ext_z;
  logic [AW-1:0] abs_x, abs_y, abs_z;
  logic [AW-1:0] mul_op;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          fits;
  logic [MW-1:0] mag_ext;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] peak_new;
  logic [MAG_W:0]   count_inc;
  logic             close;

  // mask to the sample width and take magnitude of the two's complement value
  assign ext_x = AW'(accel_x_i[CW-1:0]);
  assign ext_y = AW'(accel_y_i[CW-1:0]);
  assign ext_z = AW'(accel_z_i[CW-1:0]);
  assign abs_x = ext_x[AW-1] ? (~ext_x + AW'(1)) : ext_x;
  assign abs_y = ext_y[AW-1] ? (~ext_y + AW'(1)) : ext_y;
  assign abs_z = ext_z[AW-1] ? (~ext_z + AW'(1)) : ext_z;

  always_comb begin
    case (cmd_i.axis)
      AXIS_X:  mul_op = ax_q;
      AXIS_Y:  mul_op = ay_q;
      AXIS_Z:  mul_op = az_q;
      default: mul_op = '0;
    endcase
  end

  // one root bit per step from the next two radicand bits
  assign rem_sh = {rem_q, acc_q[SW-1 -: 2]};
  assign trial  = (RW+2)'({root_q, 2'b01});
  assign fits   = (rem_sh >= trial);

  // saturate to the output width when samples are wider than 16 bits
  assign mag_ext   = MW'(root_q);
  assign mag       = (mag_ext > MW'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : mag_ext[MAG_W-1:0];
  assign peak_new  = (mag > peak_q) ? mag : peak_q;
  assign count_inc = {1'b0, count_q} + (MAG_W+1)'(1);
  assign close     = (count_inc >= {1'b0, win_len_q});

  assign status_o.emit = close && (peak_new > thr_q);
  assign peak_magnitude_o = out_q;

  always_comb begin
    win_len_d = win_len_q;
    thr_d     = thr_q;
    count_d   = count_q;
    peak_d    = peak_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_LENGTH:   win_len_d = cfg_data_i;
        REG_SHOCK_THRESHOLD: thr_d     = cfg_data_i;
        default: ;
      endcase
    end
    if (cmd_i.upd) begin
      if (close) begin
        count_d = '0;
        peak_d  = '0;
      end else begin
        count_d = count_inc[MAG_W-1:0];
        peak_d  = peak_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_RESET;
      thr_q     <= THR_RESET;
      count_q   <= '0;
      peak_q    <= '0;
    end else begin
      win_len_q <= win_len_d;
      thr_q     <= thr_d;
      count_q   <= count_d;
      peak_q    <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= abs_x;
      ay_q   <= abs_y;
      az_q   <= abs_z;
      acc_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= SW'(mul_op) * SW'(mul_op);
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.root_en) begin
      acc_q <= {acc_q[SW-3:0], 2'b00};
      if (fits) begin
        rem_q  <= RW'(rem_sh - trial);
        root_q <= {root_q[AW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[RW-1:0];
        root_q <= {root_q[AW-2:0], 1'b0};
      end
    end
    if (cmd_i.upd && status_o.emit) begin
      out_q <= peak_new;
    end
  end

endmodule

// File: src/amp_ctrl.sv
// controller: sequences squaring, root steps and the window update per sample
`timescale 1ns / 1ps
module amp_ctrl
  import amp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output amp_cmd_t    cmd_o,
  input  amp_status_t status_i
);

  localparam int unsigned CNT_W   = $clog2(SAMPLE_BITS);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(SAMPLE_BITS - 1);

  amp_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // product registered in the step before its accumulate
        cmd_o.axis   = cnt_q[1:0];
        cmd_o.mul_en = (cnt_q != SQ_LAST);
        cmd_o.acc_en = (cnt_q != '0);
        if (cnt_q == SQ_LAST) begin
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_ROOT: begin
        cmd_o.root_en = 1'b1;
        if (cnt_q == ROOT_LAST) begin
          state_d = ST_UPDATE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        // hold while a previous word still occupies the output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || (cmd_o.upd && status_i.emit);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/accel_magnitude_peak_detector.sv
// top level of the windowed accelerometer magnitude peak detector
//
//   channel   dir  handshake       payload
//   sample_i  in   valid / ready   accel_x, accel_y, accel_z (signed 16 bit)
//   peak_o    out  valid / ready   peak_magnitude (unsigned 16 bit)
//   cfg       in   cfg_we_i        cfg_idx_i, cfg_data_i
//
// one sample steps through accept, the three axes in turn through the shared
// squaring multiplier, one root bit per cycle, and one update
// a word may wait at the output while the next sample is taken and worked on;
// only its window update stalls until that word is taken
// async active-low reset restores window length 500 and threshold 31130
`timescale 1ns / 1ps
module accel_magnitude_peak_detector
  import amp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  amp_sample_if.sink            sample_i,
  amp_peak_if.source            peak_o
);

  amp_cmd_t    cmd;
  amp_status_t status;

  amp_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (peak_o.valid),
    .out_ready_i (peak_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  amp_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .accel_x_i        (sample_i.accel_x),
    .accel_y_i        (sample_i.accel_y),
    .accel_z_i        (sample_i.accel_z),
    .cmd_i            (cmd),
    .status_o         (status),
    .peak_magnitude_o (peak_o.peak_magnitude)
  );

endmodule
